// ===== rtl/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types, constants and the arctangent table for the quaternion
// interpolation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

    // default number of cordic micro-rotations
    localparam int CORDIC_STEPS_DEF = 16;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QIDX_W = 2;

    // blend factor 1.0 in q1.15
    localparam int T_ONE = 32768;

    // reset value of the near threshold register
    localparam logic [14:0] THRESH_RESET = 15'd16;

    // mode codes
    localparam logic FUNC_SLERP = 1'b0;
    localparam logic FUNC_LERP  = 1'b1;

    // datapath widths
    localparam int SQ_STEPS = 31;   // root digits of the q60 square root
    localparam int V_W      = 62;   // radicand, padded to whole digit pairs
    localparam int REM_W    = 33;   // square root remainder
    localparam int ROOT_W   = 31;   // square root result, q30
    localparam int CW       = 34;   // cordic x, y and angles
    localparam int ZW       = 35;   // rotation residual angle
    localparam int DIV_BITS = 17;   // quotient bits of a weight
    localparam int DIV_W    = 50;   // divider remainder

    // one request after classification
    typedef struct packed {
        logic             sph;   // spherical weights wanted
        logic [27:0]      dot;   // |c| in q28, meaningful when sph is set
        logic [3:0][15:0] qa;    // first quaternion, x..w
        logic [3:0][16:0] qb;    // second quaternion after sign fix, x..w
        logic [16:0]      w0;    // linear weight of the first quaternion
        logic [16:0]      w1;    // linear weight of the second quaternion
    } job_t;

    // atan(2^-i) in q30 radians
    function automatic logic [30:0] atan_entry(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            5'd24:   v = 31'd64;
            5'd25:   v = 31'd32;
            5'd26:   v = 31'd16;
            5'd27:   v = 31'd8;
            5'd28:   v = 31'd4;
            5'd29:   v = 31'd2;
            5'd30:   v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qslerp_front.sv =====
// ----------------------------------------------------------------------------
// qslerp_front
// Accepts requests, forms the dot product, fixes the sign of the second
// quaternion, clamps the blend factor and picks spherical or linear weights.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [3:0][15:0]    qa_in,
    input  logic [3:0][15:0]    qb_in,
    input  logic [15:0]         blend,
    input  logic [14:0]         thresh,
    output logic                push_valid,
    input  logic                push_ready,
    output qslerp_pkg::job_t    push_job
);
    import qslerp_pkg::*;

    localparam logic [33:0] ONE_Q28 = 34'd1 << 28;

    logic                    s1_valid_reg;
    logic                    s1_func_reg;
    logic [3:0][15:0]        s1_qa_reg;
    logic [3:0][15:0]        s1_qb_reg;
    logic [15:0]             s1_blend_reg;
    logic signed [31:0]      s1_prod_reg [4];

    logic signed [33:0]      dot_sum;
    logic signed [33:0]      dot_abs;
    logic                    dot_neg;
    logic [15:0]             t_clamp;
    logic [33:0]             margin;
    logic [3:0][16:0]        b_ext;

    // input stage: one beat in whenever the stage is empty or drains
    assign in_ready = !s1_valid_reg || push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // component products
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_func_reg  <= func;
            s1_qa_reg    <= qa_in;
            s1_qb_reg    <= qb_in;
            s1_blend_reg <= blend;
            for (int i = 0; i < 4; i++)
            begin
                s1_prod_reg[i] <= $signed(qa_in[i]) * $signed(qb_in[i]);
            end
        end
    end

    // dot product, sign fix and classification
    always_comb
    begin
        dot_sum = 34'(s1_prod_reg[0]) + 34'(s1_prod_reg[1])
                + 34'(s1_prod_reg[2]) + 34'(s1_prod_reg[3]);
        dot_neg = dot_sum[33];
        dot_abs = dot_neg ? -dot_sum : dot_sum;
        t_clamp = (s1_blend_reg > 16'(T_ONE)) ? 16'(T_ONE) : s1_blend_reg;
        margin  = $unsigned(dot_abs) + {5'b0, thresh, 14'b0};

        for (int i = 0; i < 4; i++)
        begin
            b_ext[i] = {s1_qb_reg[i][15], s1_qb_reg[i]};
        end

        push_job.sph = (s1_func_reg == FUNC_SLERP) && (margin < ONE_Q28);
        push_job.dot = dot_abs[27:0];
        push_job.qa  = s1_qa_reg;
        for (int i = 0; i < 4; i++)
        begin
            push_job.qb[i] = dot_neg ? (~b_ext[i] + 17'd1) : b_ext[i];
        end
        push_job.w0 = 17'(T_ONE) - {1'b0, t_clamp};
        push_job.w1 = {1'b0, t_clamp};
    end

    assign push_valid = s1_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/qslerp_queue.sv =====
// ----------------------------------------------------------------------------
// qslerp_queue
// Small request queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  qslerp_pkg::job_t    push_job,
    output logic                pop_valid,
    input  logic                pop_ready,
    output qslerp_pkg::job_t    pop_job
);
    import qslerp_pkg::*;

    job_t                slot_reg [QDEPTH];
    logic [QIDX_W-1:0]   wr_ptr_reg;
    logic [QIDX_W-1:0]   rd_ptr_reg;
    logic [QIDX_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QIDX_W + 1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qslerp_angle.sv =====
// ----------------------------------------------------------------------------
// qslerp_angle
// Half angle from the dot product: sine by a digit-per-stage square root,
// then atan2 by a pipelined vectoring cordic.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_angle #(
    parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  qslerp_pkg::job_t            in_job,
    output logic                        out_valid,
    output qslerp_pkg::job_t            out_job,
    output logic signed [qslerp_pkg::CW-1:0] out_theta
);
    import qslerp_pkg::*;

    logic [55:0]             cc;

    // square root pipeline, index 0 is the radicand stage
    logic                    rv_reg   [SQ_STEPS+1];
    job_t                    rjob_reg [SQ_STEPS+1];
    logic [V_W-1:0]          rad_reg  [SQ_STEPS+1];
    logic [REM_W-1:0]        rem_reg  [SQ_STEPS+1];
    logic [ROOT_W-1:0]       root_reg [SQ_STEPS+1];

    // vectoring cordic, index 0 is the load stage
    logic                    cv_reg   [CORDIC_STEPS+1];
    job_t                    cjob_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0]    cx_reg   [CORDIC_STEPS+1];
    logic signed [CW-1:0]    cy_reg   [CORDIC_STEPS+1];
    logic signed [CW-1:0]    cz_reg   [CORDIC_STEPS+1];

    // c^2 in q56; the radicand 1 - c^2 is formed from it in q60
    assign cc = 56'(in_job.dot) * 56'(in_job.dot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            rv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rjob_reg[0] <= in_job;
            rad_reg[0]  <= (62'd1 << 60) - {2'b00, cc, 4'b0000};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // one root digit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_root
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             ge;

        assign rem_sh = {rem_reg[k], rad_reg[k][V_W-1:V_W-2]};
        assign trial  = {2'b00, root_reg[k], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                rv_reg[k+1] <= rv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rjob_reg[k+1] <= rjob_reg[k];
                rad_reg[k+1]  <= {rad_reg[k][V_W-3:0], 2'b00};
                rem_reg[k+1]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], ge};
            end
        end
    end

    // cordic load: x = c in q30, y = root
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            cv_reg[0] <= rv_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cjob_reg[0] <= rjob_reg[SQ_STEPS];
            cx_reg[0]   <= $signed({4'b0, rjob_reg[SQ_STEPS].dot, 2'b00});
            cy_reg[0]   <= $signed({3'b0, root_reg[SQ_STEPS]});
            cz_reg[0]   <= '0;
        end
    end

    // one micro-rotation per stage, driving y to zero
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] ang;

        assign dx  = cy_reg[i] >>> i;
        assign dy  = cx_reg[i] >>> i;
        assign ang = $signed({3'b000, atan_entry(5'(i))});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cjob_reg[i+1] <= cjob_reg[i];
                if (!cy_reg[i][CW-1])
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + ang;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - ang;
                end
            end
        end
    end

    assign out_valid = cv_reg[CORDIC_STEPS];
    assign out_job   = cjob_reg[CORDIC_STEPS];
    assign out_theta = cz_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

// ===== rtl/qslerp_weight.sv =====
// ----------------------------------------------------------------------------
// qslerp_weight
// Spherical weights: scaled angles, three rotation cordic lanes for the
// sines, two restoring dividers, then the choice against linear weights.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_weight #(
    parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  qslerp_pkg::job_t            in_job,
    input  logic signed [qslerp_pkg::CW-1:0] in_theta,
    output logic                        out_valid,
    output qslerp_pkg::job_t            out_job,
    output logic [16:0]                 out_w0,
    output logic [16:0]                 out_w1
);
    import qslerp_pkg::*;

    localparam logic [16:0] W_ONE = 17'(T_ONE);

    logic signed [51:0]      pm0;
    logic signed [51:0]      pm1;

    // sine lanes: 0 theta, 1 theta*(1-t), 2 theta*t
    logic                    sv_reg   [CORDIC_STEPS+1];
    job_t                    sjob_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0]    sx_reg   [3][CORDIC_STEPS+1];
    logic signed [CW-1:0]    sy_reg   [3][CORDIC_STEPS+1];
    logic signed [ZW-1:0]    sz_reg   [3][CORDIC_STEPS+1];

    // divider lanes, index 0 is the load stage
    logic                    dv_reg   [DIV_BITS+1];
    job_t                    djob_reg [DIV_BITS+1];
    logic [CW-1:0]           dden_reg [DIV_BITS+1];
    logic                    dpos_reg [DIV_BITS+1];
    logic                    dnz_reg  [2][DIV_BITS+1];
    logic                    dbig_reg [2][DIV_BITS+1];
    logic [DIV_W-1:0]        drem_reg [2][DIV_BITS+1];
    logic [DIV_BITS-1:0]     dq_reg   [2][DIV_BITS+1];

    logic                    ov_reg;
    job_t                    ojob_reg;
    logic [16:0]             ow0_reg;
    logic [16:0]             ow1_reg;

    logic signed [CW-1:0]    sth;

    // scaled angles, rounded half up
    assign pm0 = 52'(in_theta) * 52'($signed({1'b0, in_job.w0})) + 52'sd16384;
    assign pm1 = 52'(in_theta) * 52'($signed({1'b0, in_job.w1})) + 52'sd16384;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sjob_reg[0] <= in_job;
            for (int j = 0; j < 3; j++)
            begin
                sx_reg[j][0] <= CW'(64'sd1 <<< 30);
                sy_reg[j][0] <= '0;
            end
            sz_reg[0][0] <= ZW'(in_theta);
            sz_reg[1][0] <= ZW'($signed(pm0[15+CW-1:15]));
            sz_reg[2][0] <= ZW'($signed(pm1[15+CW-1:15]));
        end
    end

    // rotation cordic, all lanes in step
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        logic signed [ZW-1:0] ang;

        assign ang = $signed({4'b0000, atan_entry(5'(i))});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[i+1] <= sv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sjob_reg[i+1] <= sjob_reg[i];
            end
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;

            assign dx = sy_reg[j][i] >>> i;
            assign dy = sx_reg[j][i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!sz_reg[j][i][ZW-1])
                    begin
                        sx_reg[j][i+1] <= sx_reg[j][i] - dx;
                        sy_reg[j][i+1] <= sy_reg[j][i] + dy;
                        sz_reg[j][i+1] <= sz_reg[j][i] - ang;
                    end
                    else
                    begin
                        sx_reg[j][i+1] <= sx_reg[j][i] + dx;
                        sy_reg[j][i+1] <= sy_reg[j][i] - dy;
                        sz_reg[j][i+1] <= sz_reg[j][i] + ang;
                    end
                end
            end
        end
    end

    // divider load: rounded dividend and range flags
    assign sth = sy_reg[0][CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= sv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            djob_reg[0] <= sjob_reg[CORDIC_STEPS];
            dden_reg[0] <= sth;
            dpos_reg[0] <= !sth[CW-1] && (sth != '0);
            for (int j = 0; j < 2; j++)
            begin
                dnz_reg[j][0]  <= !sy_reg[j+1][CORDIC_STEPS][CW-1]
                                  && (sy_reg[j+1][CORDIC_STEPS] != '0);
                dbig_reg[j][0] <= $signed({sy_reg[j+1][CORDIC_STEPS][CW-1],
                                           sy_reg[j+1][CORDIC_STEPS]})
                                  >= $signed({sth, 1'b0});
                drem_reg[j][0] <= {1'b0, sy_reg[j+1][CORDIC_STEPS], 15'b0}
                                  + {17'b0, sth[CW-1:1]};
                dq_reg[j][0]   <= '0;
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < DIV_BITS; s++)
    begin : g_div
        localparam int KB = DIV_BITS - 1 - s;
        logic [DIV_W-1:0] dsh;

        assign dsh = {16'b0, dden_reg[s]} << KB;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[s+1] <= dv_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                djob_reg[s+1] <= djob_reg[s];
                dden_reg[s+1] <= dden_reg[s];
                dpos_reg[s+1] <= dpos_reg[s];
                for (int j = 0; j < 2; j++)
                begin
                    dnz_reg[j][s+1]  <= dnz_reg[j][s];
                    dbig_reg[j][s+1] <= dbig_reg[j][s];
                    if (drem_reg[j][s] >= dsh)
                    begin
                        drem_reg[j][s+1] <= drem_reg[j][s] - dsh;
                        dq_reg[j][s+1]   <= {dq_reg[j][s][DIV_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[j][s+1] <= drem_reg[j][s];
                        dq_reg[j][s+1]   <= {dq_reg[j][s][DIV_BITS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // weight choice: clamped quotients, or linear when the job is not spherical or the sine is not positive
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= dv_reg[DIV_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ojob_reg <= djob_reg[DIV_BITS];
            if (djob_reg[DIV_BITS].sph && dpos_reg[DIV_BITS])
            begin
                if (!dnz_reg[0][DIV_BITS])
                    ow0_reg <= '0;
                else if (dbig_reg[0][DIV_BITS] || dq_reg[0][DIV_BITS] > W_ONE)
                    ow0_reg <= W_ONE;
                else
                    ow0_reg <= dq_reg[0][DIV_BITS];
                if (!dnz_reg[1][DIV_BITS])
                    ow1_reg <= '0;
                else if (dbig_reg[1][DIV_BITS] || dq_reg[1][DIV_BITS] > W_ONE)
                    ow1_reg <= W_ONE;
                else
                    ow1_reg <= dq_reg[1][DIV_BITS];
            end
            else
            begin
                ow0_reg <= djob_reg[DIV_BITS].w0;
                ow1_reg <= djob_reg[DIV_BITS].w1;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_job   = ojob_reg;
    assign out_w0    = ow0_reg;
    assign out_w1    = ow1_reg;

endmodule

`default_nettype wire

// ===== rtl/qslerp_blend.sv =====
// ----------------------------------------------------------------------------
// qslerp_blend
// Weighted sum of the two quaternions, rounded and saturated to q2.14,
// ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  qslerp_pkg::job_t    in_job,
    input  logic [16:0]         in_w0,
    input  logic [16:0]         in_w1,
    output logic                out_valid,
    output logic [3:0][15:0]    out_q,
    output logic                out_sat
);
    import qslerp_pkg::*;

    logic                    pv_reg;
    logic signed [33:0]      pa_reg [4];
    logic signed [34:0]      pb_reg [4];
    logic                    ov_reg;
    logic [3:0][15:0]        oq_reg;
    logic                    osat_reg;

    logic signed [35:0]      acc   [4];
    logic [3:0][15:0]        clip;
    logic [3:0]              over;

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= in_valid;
            ov_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pa_reg[i] <= 34'($signed(in_job.qa[i])) * 34'($signed({1'b0, in_w0}));
                pb_reg[i] <= 35'($signed(in_job.qb[i])) * 35'($signed({1'b0, in_w1}));
            end
        end
    end

    // rounding and saturation
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc[i]  = 36'(pa_reg[i]) + 36'(pb_reg[i]) + 36'sd16384;
            over[i] = (acc[i][35:30] != {6{acc[i][30]}});
            if (!over[i])
                clip[i] = acc[i][30:15];
            else if (acc[i][35])
                clip[i] = 16'h8000;
            else
                clip[i] = 16'h7fff;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oq_reg   <= clip;
            osat_reg <= |over;
        end
    end

    assign out_valid = ov_reg;
    assign out_q     = oq_reg;
    assign out_sat   = osat_reg;

endmodule

`default_nettype wire

// ===== rtl/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp
// Spherical or linear interpolation between two q2.14 quaternions.
//
//   channel   signals                          direction  beat
//   cfg       cfg_we, cfg_wdata                in         near threshold write
//   in        in_valid/in_ready + fields       in         one request
//   out       out_valid/out_ready + fields     out        one result
//
// One request per cycle sustained while out_ready holds; the path runs
// through the 31-digit square root, the two cordic pipelines and the
// 17-bit dividers. The front stage and a four-entry queue let requests
// come in while the back pipeline is stalled by out_ready. Reset clears
// all valid flags and loads the threshold with 16; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp #(
    parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [14:0]  cfg_wdata,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         func,
    input  logic [15:0]  first_x,
    input  logic [15:0]  first_y,
    input  logic [15:0]  first_z,
    input  logic [15:0]  first_w,
    input  logic [15:0]  second_x,
    input  logic [15:0]  second_y,
    input  logic [15:0]  second_z,
    input  logic [15:0]  second_w,
    input  logic [15:0]  blend,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [15:0]  out_x,
    output logic [15:0]  out_y,
    output logic [15:0]  out_z,
    output logic [15:0]  out_w,
    output logic         saturated
);
    import qslerp_pkg::*;

    logic [14:0]       near_threshold_reg;
    logic              back_en;

    logic              push_valid;
    logic              push_ready;
    job_t              push_job;
    logic              pop_valid;
    job_t              pop_job;

    logic              ang_valid;
    job_t              ang_job;
    logic signed [CW-1:0] ang_theta;

    logic              wt_valid;
    job_t              wt_job;
    logic [16:0]       wt_w0;
    logic [16:0]       wt_w1;

    logic [3:0][15:0]  res_q;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            near_threshold_reg <= cfg_wdata;
        end
    end

    // back pipeline moves whenever the output register is free
    assign back_en = !out_valid || out_ready;

    qslerp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .qa_in      ({first_w, first_z, first_y, first_x}),
        .qb_in      ({second_w, second_z, second_y, second_x}),
        .blend      (blend),
        .thresh     (near_threshold_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    qslerp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (back_en),
        .pop_job    (pop_job)
    );

    qslerp_angle #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (back_en),
        .in_valid   (pop_valid),
        .in_job     (pop_job),
        .out_valid  (ang_valid),
        .out_job    (ang_job),
        .out_theta  (ang_theta)
    );

    qslerp_weight #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_weight (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (back_en),
        .in_valid   (ang_valid),
        .in_job     (ang_job),
        .in_theta   (ang_theta),
        .out_valid  (wt_valid),
        .out_job    (wt_job),
        .out_w0     (wt_w0),
        .out_w1     (wt_w1)
    );

    qslerp_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (back_en),
        .in_valid   (wt_valid),
        .in_job     (wt_job),
        .in_w0      (wt_w0),
        .in_w1      (wt_w1),
        .out_valid  (out_valid),
        .out_q      (res_q),
        .out_sat    (saturated)
    );

    assign out_x = res_q[0];
    assign out_y = res_q[1];
    assign out_z = res_q[2];
    assign out_w = res_q[3];

endmodule

`default_nettype wire
